/* rtl/core/skti_pkg.sv */
// ----------------------------------------------------------------------------
// skti_pkg
// Shared types and codes for the sorted key table with insertion.
// ----------------------------------------------------------------------------
package skti_pkg;

    localparam int KEY_W   = 32;
    localparam int REC_W   = 32;
    localparam int SLOT_W  = 10;
    localparam int CNT_W   = 11;

    // Function code on the input port that selects a read.
    localparam logic FUNC_READ = 1'b1;

    // Size register value after reset.
    localparam logic [CNT_W-1:0] TABLE_SIZE_RST = 11'd1024;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    // Classified command handed from the front to the back.
    typedef struct packed {
        t_op               op;
        logic [KEY_W-1:0]  key;
        logic [REC_W-1:0]  record;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    // One result beat.
    typedef struct packed {
        logic [SLOT_W-1:0] position;
        logic [KEY_W-1:0]  key_out;
        logic [REC_W-1:0]  record_out;
        logic              occupied;
        logic              full_res;
        logic [CNT_W-1:0]  fill_count;
    } t_res;

endpackage

/* rtl/core/sorted_key_table_insert.sv */
// ----------------------------------------------------------------------------
// sorted_key_table_insert
// A read answers from the read wait state after it leaves the input queue;
// an insert shifts each larger key up one slot, top down, then fills the gap.
// A refused insert or an insert into an empty table is answered from idle.
// The next item starts only once the previous result has been popped. Reset
// empties the table at once by clearing the fill count, not the storage.
// ----------------------------------------------------------------------------
module sorted_key_table_insert
    import skti_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Input queue side.
    input  logic              push,
    output logic              full,
    input  logic              i_func,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [REC_W-1:0]  i_record,
    input  logic [SLOT_W-1:0] i_slot,
    // Result queue side.
    output logic              empty,
    input  logic              pop,
    output logic [SLOT_W-1:0] o_position,
    output logic [KEY_W-1:0]  o_key_out,
    output logic [REC_W-1:0]  o_record_out,
    output logic              o_occupied,
    output logic              o_full_res,
    output logic [CNT_W-1:0]  o_fill_count,
    // Size register write channel.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data
);

    // The front end queues classified beats so the producer is not held off
    // while the back end walks the table. The back end owns the key and
    // record memories and the fill count. A single result register sits at
    // the output; the back end starts a command only when it is free, so a
    // result waiting to be popped holds the back end, and input beats keep
    // queuing in the front until its two entries are taken.

    logic [CNT_W-1:0] r_table_size;
    logic             r_out_valid;
    t_res             r_out;

    logic             cmd_valid;
    t_cmd             cmd;
    logic             cmd_take;
    logic             res_valid;
    t_res             res;

    // The size register can be written at any time the host chooses.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_table_size <= i_cfg_data;
        end
    end

    skti_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_record    (i_record),
        .i_slot      (i_slot),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    skti_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_table_size (r_table_size),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_take   (cmd_take),
        .i_res_free   (!r_out_valid),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Output register. The back end only delivers a beat while the register
    // is empty, so a load and a pop never meet in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (pop && r_out_valid) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign empty        = !r_out_valid;
    assign o_position   = r_out.position;
    assign o_key_out    = r_out.key_out;
    assign o_record_out = r_out.record_out;
    assign o_occupied   = r_out.occupied;
    assign o_full_res   = r_out.full_res;
    assign o_fill_count = r_out.fill_count;

endmodule

/* rtl/core/skti_front.sv */
// ----------------------------------------------------------------------------
// skti_front
// Accepts input beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module skti_front
    import skti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_func,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [REC_W-1:0]  i_record,
    input  logic [SLOT_W-1:0] i_slot,
    output logic              o_cmd_valid,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       wr;
    t_cmd       cmd_in;

    assign o_full      = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = i_push && !o_full;

    always_comb begin
        cmd_in.op     = (i_func == FUNC_READ) ? OP_READ : OP_INSERT;
        cmd_in.key    = i_key;
        cmd_in.record = i_record;
        cmd_in.slot   = i_slot;
    end

    always_comb begin
        n_wp  = wr ? ~r_wp : r_wp;
        n_rp  = i_cmd_take ? ~r_rp : r_rp;
        n_cnt = r_cnt + {1'b0, wr} - {1'b0, i_cmd_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

/* rtl/core/skti_back.sv */
// ----------------------------------------------------------------------------
// skti_back
// Executes commands on the sorted table: reads, refused inserts, and inserts
// that walk down from the top entry, moving one entry up per cycle.
// ----------------------------------------------------------------------------
module skti_back
    import skti_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_table_size,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    output logic             o_cmd_take,
    input  logic             i_res_free,
    output logic             o_res_valid,
    output t_res             o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CNT_W) ? CW : CNT_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RDWAIT = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_PLACE  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    logic [AW-1:0]    r_j, n_j;
    logic [KEY_W-1:0] r_key, n_key;
    logic [REC_W-1:0] r_rec, n_rec;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic             r_hit, n_hit;

    logic [KEY_W-1:0] mem_key [DEPTH];
    logic [REC_W-1:0] mem_rec [DEPTH];
    logic [KEY_W-1:0] r_rd_key;
    logic [REC_W-1:0] r_rd_rec;

    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             we;
    logic [AW-1:0]    wa;
    logic [KEY_W-1:0] wkey;
    logic [REC_W-1:0] wrec;

    logic             full_now;
    logic [CW-1:0]    count_m1;
    logic [AW+SLOT_W-1:0] slot_ext;
    logic [AW+SLOT_W-1:0] j_ext;
    logic [CW+CNT_W-1:0]  cnt_ext;
    logic [LW-1:0]    slot_lw;
    logic [LW-1:0]    count_lw;
    logic [LW-1:0]    size_lw;

    assign count_lw = LW'(r_count);
    assign size_lw  = LW'(i_table_size);
    assign full_now = (count_lw >= size_lw) || (r_count == CW'(DEPTH));
    assign count_m1 = r_count - CW'(1);
    assign slot_ext = {{AW{1'b0}}, i_cmd.slot};
    assign slot_lw  = LW'(i_cmd.slot);
    assign j_ext    = {{SLOT_W{1'b0}}, r_j};
    assign cnt_ext  = {{CNT_W{1'b0}}, n_count};

    assign o_cmd_take = (r_state == ST_IDLE) && i_cmd_valid && i_res_free;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_j     = r_j;
        n_key   = r_key;
        n_rec   = r_rec;
        n_slot  = r_slot;
        n_hit   = r_hit;
        rd_en   = 1'b0;
        rd_addr = r_j - AW'(1);
        we      = 1'b0;
        wa      = r_j;
        wkey    = r_key;
        wrec    = r_rec;
        o_res_valid       = 1'b0;
        o_res.position    = j_ext[SLOT_W-1:0];
        o_res.key_out     = r_key;
        o_res.record_out  = r_rec;
        o_res.occupied    = 1'b1;
        o_res.full_res    = 1'b0;
        o_res.fill_count  = cnt_ext[CNT_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd_take) begin
                    n_key  = i_cmd.key;
                    n_rec  = i_cmd.record;
                    n_slot = i_cmd.slot;
                    unique case (i_cmd.op)
                        OP_READ: begin
                            rd_en   = 1'b1;
                            rd_addr = slot_ext[AW-1:0];
                            n_hit   = (count_lw > slot_lw)
                                   && (slot_lw < LW'(DEPTH));
                            n_state = ST_RDWAIT;
                        end
                        OP_INSERT: begin
                            if (full_now) begin
                                // Refused insert: table untouched.
                                o_res_valid      = 1'b1;
                                o_res.position   = '0;
                                o_res.key_out    = '0;
                                o_res.record_out = '0;
                                o_res.occupied   = 1'b0;
                                o_res.full_res   = 1'b1;
                            end else if (r_count == '0) begin
                                we               = 1'b1;
                                wa               = '0;
                                wkey             = i_cmd.key;
                                wrec             = i_cmd.record;
                                n_count          = r_count + CW'(1);
                                o_res_valid      = 1'b1;
                                o_res.position   = '0;
                                o_res.key_out    = i_cmd.key;
                                o_res.record_out = i_cmd.record;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = count_m1[AW-1:0];
                                n_j     = r_count[AW-1:0];
                                n_state = ST_SHIFT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RDWAIT: begin
                o_res_valid      = 1'b1;
                o_res.position   = r_slot;
                o_res.key_out    = r_hit ? r_rd_key : '0;
                o_res.record_out = r_hit ? r_rd_rec : '0;
                o_res.occupied   = r_hit;
                n_state          = ST_IDLE;
            end
            ST_SHIFT: begin
                // r_rd_key holds the entry just below slot r_j.
                we = 1'b1;
                wa = r_j;
                if (r_rd_key > r_key) begin
                    wkey = r_rd_key;
                    wrec = r_rd_rec;
                    n_j  = r_j - AW'(1);
                    if (r_j == AW'(1)) begin
                        n_state = ST_PLACE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_j - AW'(1) - AW'(1);
                    end
                end else begin
                    n_count     = r_count + CW'(1);
                    o_res_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            ST_PLACE: begin
                we          = 1'b1;
                wa          = '0;
                n_count     = r_count + CW'(1);
                o_res_valid = 1'b1;
                n_state     = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j    <= n_j;
        r_key  <= n_key;
        r_rec  <= n_rec;
        r_slot <= n_slot;
        r_hit  <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem_key[wa] <= wkey;
            mem_rec[wa] <= wrec;
        end
        if (rd_en) begin
            r_rd_key <= mem_key[rd_addr];
            r_rd_rec <= mem_rec[rd_addr];
        end
    end

endmodule

/* rtl/core/skti_checker.sv */
// ----------------------------------------------------------------------------
// skti_checker
// Port-level checks for the sorted key table, bound to the top level.
// ----------------------------------------------------------------------------
module skti_checker
    import skti_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input logic [SLOT_W-1:0] o_position,
    input logic [KEY_W-1:0]  o_key_out,
    input logic [REC_W-1:0]  o_record_out,
    input logic              o_occupied,
    input logic              o_full_res
);

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A result that is not taken stays as it is.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_key_out)
                              && $stable(o_record_out) && $stable(o_position)))
        else $error("waiting result changed before pop");

    // A refused insert carries no entry.
    a_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_full_res) |-> (!o_occupied && o_position == '0
                                    && o_key_out == '0 && o_record_out == '0))
        else $error("refused insert carries entry data");

endmodule

bind sorted_key_table_insert skti_checker u_skti_checker (.*);

/* verif/skti_result_checker.sv */
// ----------------------------------------------------------------------------
// skti_result_checker
// Watches the command, result and size register channels of the sorted key
// table, keeps its own copy of the table, and compares every result beat
// with the expected one.
// ----------------------------------------------------------------------------
module skti_result_checker
    import skti_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic              i_func,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [REC_W-1:0]  i_record,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [SLOT_W-1:0] i_position,
    input  logic [KEY_W-1:0]  i_key_out,
    input  logic [REC_W-1:0]  i_record_out,
    input  logic              i_occupied,
    input  logic              i_full_res,
    input  logic [CNT_W-1:0]  i_fill_count,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [CNT_W-1:0]  i_cfg_data,
    output int                o_fails,
    output int                o_pending,
    output int                o_entries,
    output int                o_landed,
    output int                o_refused,
    output int                o_read_hits,
    output int                o_read_misses
);

    localparam int MAX_PRINTS = 40;

    logic [KEY_W-1:0] key_tab [DEPTH];
    logic [REC_W-1:0] rec_tab [DEPTH];
    int               entries;
    logic [CNT_W-1:0] size_reg;
    t_res             expected_q [$];
    t_cmd             cmd_now;
    t_res             want;
    t_res             got;
    int               fails;
    int               beats;
    int               landed;
    int               refused;
    int               read_hits;
    int               read_misses;

    task automatic report_failure(input string msg);
        fails++;
        if (fails <= MAX_PRINTS) begin
            $display("[%0t] %s", $time, msg);
        end
    endtask

    // Applies one command to the shadow table and returns the beat it causes.
    task automatic apply_cmd(input t_cmd cmd, output t_res res);
        int lim;
        int at;
        res = '0;
        if (cmd.op == OP_READ) begin
            res.position = cmd.slot;
            if (int'(cmd.slot) < entries && int'(cmd.slot) < DEPTH) begin
                res.key_out    = key_tab[cmd.slot];
                res.record_out = rec_tab[cmd.slot];
                res.occupied   = 1'b1;
                read_hits++;
            end else begin
                read_misses++;
            end
        end else begin
            lim = (int'(size_reg) > DEPTH) ? DEPTH : int'(size_reg);
            if (entries >= lim) begin
                res.full_res = 1'b1;
                refused++;
            end else begin
                // Equal keys stay in arrival order: stop at the first larger key.
                at = 0;
                while (at < entries && key_tab[at] <= cmd.key) begin
                    at++;
                end
                for (int j = entries; j > at; j--) begin
                    key_tab[j] = key_tab[j-1];
                    rec_tab[j] = rec_tab[j-1];
                end
                key_tab[at] = cmd.key;
                rec_tab[at] = cmd.record;
                entries++;
                res.position   = SLOT_W'(at);
                res.key_out    = cmd.key;
                res.record_out = cmd.record;
                res.occupied   = 1'b1;
                landed++;
            end
        end
        res.fill_count = CNT_W'(entries);
    endtask

    task automatic check_beat(input t_res exp_beat, input t_res act_beat);
        if (act_beat.position !== exp_beat.position) begin
            report_failure($sformatf("beat %0d position: expected %0d, got %0d",
                beats, exp_beat.position, act_beat.position));
        end
        if (act_beat.key_out !== exp_beat.key_out) begin
            report_failure($sformatf("beat %0d key_out: expected %h, got %h",
                beats, exp_beat.key_out, act_beat.key_out));
        end
        if (act_beat.record_out !== exp_beat.record_out) begin
            report_failure($sformatf("beat %0d record_out: expected %h, got %h",
                beats, exp_beat.record_out, act_beat.record_out));
        end
        if (act_beat.occupied !== exp_beat.occupied) begin
            report_failure($sformatf("beat %0d occupied: expected %b, got %b",
                beats, exp_beat.occupied, act_beat.occupied));
        end
        if (act_beat.full_res !== exp_beat.full_res) begin
            report_failure($sformatf("beat %0d full_res: expected %b, got %b",
                beats, exp_beat.full_res, act_beat.full_res));
        end
        if (act_beat.fill_count !== exp_beat.fill_count) begin
            report_failure($sformatf("beat %0d fill_count: expected %0d, got %0d",
                beats, exp_beat.fill_count, act_beat.fill_count));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries  = 0;
            size_reg = TABLE_SIZE_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                size_reg = i_cfg_data;
            end
            if (i_push && !i_full) begin
                cmd_now.op     = t_op'(i_func);
                cmd_now.key    = i_key;
                cmd_now.record = i_record;
                cmd_now.slot   = i_slot;
                apply_cmd(cmd_now, want);
                expected_q.push_back(want);
            end
            if (i_pop && !i_empty) begin
                got.position   = i_position;
                got.key_out    = i_key_out;
                got.record_out = i_record_out;
                got.occupied   = i_occupied;
                got.full_res   = i_full_res;
                got.fill_count = i_fill_count;
                if (expected_q.size() == 0) begin
                    report_failure($sformatf("beat %0d arrived with nothing expected", beats));
                end else begin
                    check_beat(expected_q.pop_front(), got);
                end
                beats++;
            end
        end
        o_fails       <= fails;
        o_pending     <= expected_q.size();
        o_entries     <= entries;
        o_landed      <= landed;
        o_refused     <= refused;
        o_read_hits   <= read_hits;
        o_read_misses <= read_misses;
    end

endmodule

/* verif/tb_sorted_key_table_insert.sv */
// ----------------------------------------------------------------------------
// tb_sorted_key_table_insert
// Drives inserts and reads into the sorted key table under several table
// sizes, with random gaps on both queues, and gives the verdict from the
// failure count of the result checker.
// ----------------------------------------------------------------------------
module tb_sorted_key_table_insert
    import skti_pkg::*;
();

    localparam int DEPTH          = 1024;
    localparam int ITEM_TARGET    = 580;
    // Above this fill the random phases only pick sizes that refuse inserts,
    // which keeps the shift time of each insert well bounded.
    localparam int FILL_CEILING   = 440;
    // An insert moves fewer than DEPTH entries, since a full table refuses it, and
    // a long gap on either side adds to the wait; this limit is many times that.
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [CNT_W-1:0] SIZE_MAX = '1;

    logic              i_clk        = 1'b0;
    logic              i_rst_n      = 1'b0;
    logic              push         = 1'b0;
    logic              full;
    logic              i_func       = OP_INSERT;
    logic [KEY_W-1:0]  i_key        = '0;
    logic [REC_W-1:0]  i_record     = '0;
    logic [SLOT_W-1:0] i_slot       = '0;
    logic              empty;
    logic              pop          = 1'b0;
    logic [SLOT_W-1:0] o_position;
    logic [KEY_W-1:0]  o_key_out;
    logic [REC_W-1:0]  o_record_out;
    logic              o_occupied;
    logic              o_full_res;
    logic [CNT_W-1:0]  o_fill_count;
    logic              i_cfg_valid  = 1'b0;
    logic              o_cfg_ready;
    logic [CNT_W-1:0]  i_cfg_data   = '0;

    int fails;
    int pending;
    int entries;
    int landed;
    int refused;
    int read_hits;
    int read_misses;
    int items_sent  = 0;
    int size_writes = 0;
    int idle_cycles = 0;
    int pop_hold    = 0;
    // When set, neither side idles, so beats go back to back.
    bit burst_mode  = 1'b0;

    always #2 i_clk = ~i_clk;

    sorted_key_table_insert #(
        .DEPTH(DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_func      (i_func),
        .i_key       (i_key),
        .i_record    (i_record),
        .i_slot      (i_slot),
        .empty       (empty),
        .pop         (pop),
        .o_position  (o_position),
        .o_key_out   (o_key_out),
        .o_record_out(o_record_out),
        .o_occupied  (o_occupied),
        .o_full_res  (o_full_res),
        .o_fill_count(o_fill_count),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    skti_result_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_func       (i_func),
        .i_key        (i_key),
        .i_record     (i_record),
        .i_slot       (i_slot),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_position   (o_position),
        .i_key_out    (o_key_out),
        .i_record_out (o_record_out),
        .i_occupied   (o_occupied),
        .i_full_res   (o_full_res),
        .i_fill_count (o_fill_count),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fails      (fails),
        .o_pending    (pending),
        .o_entries    (entries),
        .o_landed     (landed),
        .o_refused    (refused),
        .o_read_hits  (read_hits),
        .o_read_misses(read_misses)
    );

    // Gap length in cycles: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode) begin
            return 0;
        end
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // The result side stalls on its own schedule. Each stall is a run of
    // cycles with pop low; in between, pop stays high.
    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                pop_hold <= pick_gap();
            end
        end
    end

    // The watchdog restarts on any accepted beat on any channel. A hang in
    // the block, a lost result or a stuck handshake all end up here.
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                idle_cycles, pending);
            $display("tb_sorted_key_table_insert failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one command beat after a random gap and returns once it has been
    // accepted. Push is left high so that a following beat with no gap goes
    // out on the very next edge without push ever dropping.
    task automatic send_item(input t_op op, input logic [KEY_W-1:0] k,
                             input logic [REC_W-1:0] r, input logic [SLOT_W-1:0] s);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push     <= 1'b1;
        i_func   <= op;
        i_key    <= k;
        i_record <= r;
        i_slot   <= s;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        items_sent++;
    endtask

    // Holds the command side off until every expected result has been popped.
    // The checker's outstanding count is registered, so the task lets it settle first.
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // The size register is only written while the table is quiet.
    task automatic write_size(input logic [CNT_W-1:0] value);
        wait_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        size_writes++;
    endtask

    // Sizes for a random phase. Below the fill ceiling, half leave a little room
    // above the fill so the phase both lands inserts and then runs into the limit.
    function automatic logic [CNT_W-1:0] pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (entries >= FILL_CEILING) begin
            return (roll < 50) ? CNT_W'(entries) : CNT_W'($urandom_range(0, entries));
        end
        if (roll < 50) begin
            return CNT_W'(entries + $urandom_range(1, 25));
        end
        if (roll < 65) begin
            return CNT_W'(entries);
        end
        if (roll < 75) begin
            return '0;
        end
        if (roll < 85) begin
            return SIZE_MAX;
        end
        if (roll < 92) begin
            return CNT_W'(DEPTH);
        end
        return CNT_W'($urandom_range(0, entries));
    endfunction

    // One random command. Keys come partly from a tiny range so that runs of
    // equal keys build up, partly from the two ends of the key range, and
    // otherwise from anywhere. Reads mostly hit filled slots, some land just
    // past the fill, and the rest anywhere in the slot range.
    task automatic send_random_item();
        logic [KEY_W-1:0]  k;
        logic [SLOT_W-1:0] s;
        int                roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 55) begin
            if (roll < 30) begin
                k = $urandom_range(0, 15);
            end else if (roll < 35) begin
                k = '0;
            end else if (roll < 40) begin
                k = '1;
            end else begin
                k = $urandom();
            end
            send_item(OP_INSERT, k, $urandom(), SLOT_W'($urandom_range(0, 1023)));
        end else begin
            if (roll < 70 && entries > 0) begin
                s = SLOT_W'($urandom_range(0, entries - 1));
            end else if (roll < 80) begin
                s = SLOT_W'(entries + $urandom_range(0, 3));
            end else begin
                s = SLOT_W'($urandom_range(0, 1023));
            end
            send_item(OP_READ, $urandom(), $urandom(), s);
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reads of an empty table, at both ends of the slot range.
        send_item(OP_READ, '0, '0, '0);
        send_item(OP_READ, '1, '1, '1);

        // Inserts at the front, the end and the middle, including equal keys,
        // which must land behind the entries already holding that key. The
        // size register still has its reset value here.
        send_item(OP_INSERT, 32'h8000_0000, 32'h0000_0001, '0);
        send_item(OP_INSERT, '0, 32'h0000_0002, '1);
        send_item(OP_INSERT, '1, '1, '0);
        send_item(OP_INSERT, 32'h8000_0000, 32'h0000_0003, '0);
        send_item(OP_INSERT, '0, '0, '0);
        send_item(OP_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 10'h155);
        send_item(OP_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 10'h2AA);

        // Read every filled slot back, then the first slot past the fill and
        // the last slot of all.
        for (int s = 0; s < 8; s++) begin
            send_item(OP_READ, '0, '0, SLOT_W'(s));
        end
        send_item(OP_READ, '0, '0, '1);

        // A size of zero refuses every insert, and reads keep working.
        write_size('0);
        send_item(OP_INSERT, 32'h0000_0010, 32'h0000_0010, '0);
        send_item(OP_READ, '0, '0, '0);

        // A size below the fill also refuses.
        write_size(CNT_W'(1));
        send_item(OP_INSERT, 32'h0000_0020, 32'h0000_0020, '0);

        // Room for exactly two more entries: the third insert is refused.
        write_size(CNT_W'(9));
        send_item(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0030, '0);
        send_item(OP_INSERT, 32'h0000_0001, 32'h0000_0031, '0);
        send_item(OP_INSERT, 32'h0000_0002, 32'h0000_0032, '0);

        // The largest register value is clamped to the table depth.
        write_size(SIZE_MAX);
        send_item(OP_INSERT, 32'hFFFF_FFFE, 32'h0000_0040, '0);

        // Random phases. Each one sets a fresh size while the table is quiet,
        // which also makes the sender wait for every outstanding result.
        while (items_sent < ITEM_TARGET) begin
            burst_mode <= ($urandom_range(0, 3) == 0);
            write_size(pick_size());
            repeat ($urandom_range(20, 60)) send_random_item();
        end

        burst_mode <= 1'b0;
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d commands: %0d inserts landed, %0d refused, %0d reads of %0d",
            items_sent, landed, refused, read_hits + read_misses, items_sent);
        $display("reads hit %0d filled and %0d empty slots; %0d size writes, final fill %0d",
            read_hits, read_misses, size_writes, entries);
        if (fails == 0) begin
            $display("tb_sorted_key_table_insert passed");
        end else begin
            $display("tb_sorted_key_table_insert failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/skti_pkg.sv
rtl/core/skti_front.sv
rtl/core/skti_back.sv
rtl/core/sorted_key_table_insert.sv
rtl/core/skti_checker.sv
verif/skti_result_checker.sv
verif/tb_sorted_key_table_insert.sv
